### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks sampled on clk, switched off while rst is high.
`define HHT_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

`define HHT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### sv/hht_pkg.sv
`default_nettype none

package hht_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int NBHD_DEF  = 8;

  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int HOME_W  = 10;
  localparam int USED_W  = 11;
  localparam int CODE_W  = 2;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [USED_W-1:0] USED_SIZE_RST = 11'd1024;
  localparam logic              REG_USED_SIZE = 1'b0;

  localparam logic [CODE_W-1:0] CODE_DONE = 2'd0;
  localparam logic [CODE_W-1:0] CODE_MISS = 2'd1;
  localparam logic [CODE_W-1:0] CODE_FULL = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_RD_HOME,
    OP_CAP_HOME,
    OP_RD_LK,
    OP_LK_NEXT,
    OP_RD_FREE,
    OP_FREE_NEXT,
    OP_RD_CAND,
    OP_CAP_CAND,
    OP_I_DEC,
    OP_RD_FROM,
    OP_CAP_FROM,
    OP_W_FREE,
    OP_W_FROM,
    OP_W_CAND,
    OP_W_INS,
    OP_W_HOME,
    OP_EMIT_HIT,
    OP_EMIT_PLACED,
    OP_EMIT_MISS,
    OP_EMIT_FULL
  } hht_op_t;

  typedef struct packed {
    logic clr_last;
    logic home_ok;
    logic lk_end;
    logic lk_cand;
    logic lk_hit;
    logic scan_ok;
    logic free_occ;
    logic near;
    logic j_found;
    logic i_last;
    logic out_free;
  } hht_st_t;

endpackage

`default_nettype wire

### sv/hht_if.sv
`default_nettype none

interface hht_req_if;
  import hht_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic signed [KEY_W-1:0] key;
  logic signed [VAL_W-1:0] entry_value;
  logic [HOME_W-1:0]       home_bucket;

  modport source (output valid, command, key, entry_value, home_bucket, input ready);
  modport sink (input valid, command, key, entry_value, home_bucket, output ready);
endinterface

interface hht_rsp_if;
  import hht_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CODE_W-1:0]       result_code;
  logic signed [VAL_W-1:0] found_value;
  logic [HOME_W-1:0]       slot;

  modport source (output valid, result_code, found_value, slot, input ready);
  modport sink (input valid, result_code, found_value, slot, output ready);
endinterface

`default_nettype wire

### sv/hht_ctrl.sv
`default_nettype none

module hht_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            in_insert,
  input  wire hht_pkg::hht_st_t st,
  output hht_pkg::hht_op_t     op,
  output logic                 in_ready
);
  import hht_pkg::*;

  typedef enum logic [20:0] {
    S_CLEAR    = 21'h000001,
    S_IDLE     = 21'h000002,
    S_LK_HOME  = 21'h000004,
    S_LK_CAP   = 21'h000008,
    S_LK_ISSUE = 21'h000010,
    S_LK_CHK   = 21'h000020,
    S_SCAN     = 21'h000040,
    S_SCAN_CHK = 21'h000080,
    S_DISP     = 21'h000100,
    S_CAND_CAP = 21'h000200,
    S_FROM_RD  = 21'h000400,
    S_FROM_CAP = 21'h000800,
    S_FREE_RD  = 21'h001000,
    S_W_FREE   = 21'h002000,
    S_W_FROM   = 21'h004000,
    S_W_CAND   = 21'h008000,
    S_FIN_RD   = 21'h010000,
    S_W_INS    = 21'h020000,
    S_HOME_RD  = 21'h040000,
    S_W_HOME   = 21'h080000,
    S_EMIT     = 21'h100000
  } state_t;

  state_t  state, state_next;
  hht_op_t emit_op, emit_op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      emit_op <= OP_EMIT_MISS;
    end else begin
      state   <= state_next;
      emit_op <= emit_op_next;
    end
  end

  always_comb begin
    state_next   = state;
    emit_op_next = emit_op;
    op           = OP_NONE;
    in_ready     = 1'b0;
    unique case (state)
      S_CLEAR: begin
        op = OP_CLEAR;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op         = OP_LOAD;
          state_next = in_insert ? S_SCAN : S_LK_HOME;
        end
      end
      S_LK_HOME: begin
        if (!st.home_ok) begin
          emit_op_next = OP_EMIT_MISS;
          state_next   = S_EMIT;
        end else begin
          op         = OP_RD_HOME;
          state_next = S_LK_CAP;
        end
      end
      S_LK_CAP: begin
        op         = OP_CAP_HOME;
        state_next = S_LK_ISSUE;
      end
      S_LK_ISSUE: begin
        if (st.lk_end) begin
          emit_op_next = OP_EMIT_MISS;
          state_next   = S_EMIT;
        end else if (st.lk_cand) begin
          op         = OP_RD_LK;
          state_next = S_LK_CHK;
        end else begin
          op = OP_LK_NEXT;
        end
      end
      S_LK_CHK: begin
        if (st.lk_hit) begin
          emit_op_next = OP_EMIT_HIT;
          state_next   = S_EMIT;
        end else begin
          op         = OP_LK_NEXT;
          state_next = S_LK_ISSUE;
        end
      end
      S_SCAN: begin
        if (!st.scan_ok) begin
          emit_op_next = OP_EMIT_FULL;
          state_next   = S_EMIT;
        end else begin
          op         = OP_RD_FREE;
          state_next = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (st.free_occ) begin
          op         = OP_FREE_NEXT;
          state_next = S_SCAN;
        end else begin
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (st.near) begin
          state_next = S_FIN_RD;
        end else begin
          op         = OP_RD_CAND;
          state_next = S_CAND_CAP;
        end
      end
      S_CAND_CAP: begin
        if (st.j_found) begin
          op         = OP_CAP_CAND;
          state_next = S_FROM_RD;
        end else if (st.i_last) begin
          emit_op_next = OP_EMIT_FULL;
          state_next   = S_EMIT;
        end else begin
          op         = OP_I_DEC;
          state_next = S_DISP;
        end
      end
      S_FROM_RD: begin
        op         = OP_RD_FROM;
        state_next = S_FROM_CAP;
      end
      S_FROM_CAP: begin
        op         = OP_CAP_FROM;
        state_next = S_FREE_RD;
      end
      S_FREE_RD: begin
        op         = OP_RD_FREE;
        state_next = S_W_FREE;
      end
      S_W_FREE: begin
        op         = OP_W_FREE;
        state_next = S_W_FROM;
      end
      S_W_FROM: begin
        op         = OP_W_FROM;
        state_next = S_W_CAND;
      end
      S_W_CAND: begin
        op         = OP_W_CAND;
        state_next = S_DISP;
      end
      S_FIN_RD: begin
        op         = OP_RD_FREE;
        state_next = S_W_INS;
      end
      S_W_INS: begin
        op         = OP_W_INS;
        state_next = S_HOME_RD;
      end
      S_HOME_RD: begin
        op         = OP_RD_HOME;
        state_next = S_W_HOME;
      end
      S_W_HOME: begin
        op           = OP_W_HOME;
        emit_op_next = OP_EMIT_PLACED;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          op         = emit_op;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

`default_nettype wire

### sv/hht_dp.sv
`default_nettype none

module hht_dp #(
  parameter int TABLE_DEPTH  = hht_pkg::DEPTH_DEF,
  parameter int NEIGHBORHOOD = hht_pkg::NBHD_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire hht_pkg::hht_op_t                 op,
  output hht_pkg::hht_st_t                      st,
  input  wire logic signed [hht_pkg::KEY_W-1:0] in_key,
  input  wire logic signed [hht_pkg::VAL_W-1:0] in_value,
  input  wire logic [hht_pkg::HOME_W-1:0]       in_home,
  input  wire logic [hht_pkg::USED_W-1:0]       used_size,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [hht_pkg::CODE_W-1:0]            out_code,
  output logic signed [hht_pkg::VAL_W-1:0]      out_value,
  output logic [hht_pkg::HOME_W-1:0]            out_slot
);
  import hht_pkg::*;

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int PW0 = $clog2(TABLE_DEPTH + NEIGHBORHOOD) + 1;
  localparam int PW  = (PW0 > USED_W) ? PW0 : USED_W;
  localparam int IW  = $clog2(NEIGHBORHOOD);
  localparam int LW  = $clog2(NEIGHBORHOOD + 1);
  localparam int N   = NEIGHBORHOOD;
  localparam int MW  = NEIGHBORHOOD + 1;
  localparam int KW  = KEY_W + VAL_W;

  // meta row: {occupied, hop bitmap}
  logic [MW-1:0] meta_mem [TABLE_DEPTH];
  logic [KW-1:0] kv_mem   [TABLE_DEPTH];
  logic [MW-1:0] rd_meta;
  logic [KW-1:0] rd_kv;

  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic [PW-1:0]    h_r, freeb, cand_r, from_r;
  logic [IW-1:0]    i_r;
  logic [LW-1:0]    li;
  logic [N-1:0]     hop_r, newbits_r, from_hop_r;
  logic             cand_occ_r, from_occ_r;
  logic [KW-1:0]    from_kv_r;
  logic [AW-1:0]    clr;

  logic [PW-1:0] size_eff, cand_pos, lk_pos, span, rd_addr, wr_addr;
  logic [IW-1:0] j;
  logic          j_found, rd_en, wr_meta, wr_kv;
  logic [MW-1:0] wr_meta_data;
  logic [KW-1:0] wr_kv_data;
  logic [N-1:0]  rd_hop;

  assign rd_hop   = rd_meta[N-1:0];
  assign cand_pos = freeb - PW'(i_r);
  assign lk_pos   = h_r + PW'(li);
  assign span     = freeb - h_r;

  always_comb begin
    if (used_size == '0) begin
      size_eff = PW'(1);
    end else if (PW'(used_size) > PW'(TABLE_DEPTH)) begin
      size_eff = PW'(TABLE_DEPTH);
    end else begin
      size_eff = PW'(used_size);
    end
  end

  // lowest set hop bit below i
  always_comb begin
    j       = '0;
    j_found = 1'b0;
    for (int k = 0; k < N; k++) begin
      if (!j_found && (IW'(k) < i_r) && rd_hop[k]) begin
        j       = IW'(k);
        j_found = 1'b1;
      end
    end
  end

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = h_r;
    unique case (op) inside
      OP_RD_HOME: rd_addr = h_r;
      OP_RD_FREE: rd_addr = freeb;
      OP_RD_CAND: rd_addr = cand_pos;
      OP_RD_FROM: rd_addr = from_r;
      OP_RD_LK:   rd_addr = lk_pos;
      default:    rd_en   = 1'b0;
    endcase
  end

  always_comb begin
    wr_meta      = 1'b1;
    wr_kv        = 1'b0;
    wr_addr      = freeb;
    wr_meta_data = '0;
    wr_kv_data   = {key_r, val_r};
    unique case (op) inside
      OP_CLEAR: begin
        wr_addr      = PW'(clr);
        wr_meta_data = '0;
      end
      OP_W_FREE: begin
        wr_kv        = 1'b1;
        wr_meta_data = {from_occ_r, rd_hop};
        wr_kv_data   = from_kv_r;
      end
      OP_W_FROM: begin
        wr_addr      = from_r;
        wr_meta_data = {1'b0, from_hop_r};
      end
      OP_W_CAND: begin
        wr_addr      = cand_r;
        wr_meta_data = {(cand_r == from_r) ? 1'b0 : cand_occ_r, newbits_r};
      end
      OP_W_INS: begin
        wr_kv        = 1'b1;
        wr_meta_data = {1'b1, rd_hop};
      end
      OP_W_HOME: begin
        wr_addr      = h_r;
        wr_meta_data = {rd_meta[N], rd_hop | (N'(1) << span[IW-1:0])};
      end
      default: wr_meta = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_meta) meta_mem[wr_addr[AW-1:0]] <= wr_meta_data;
    if (wr_kv) kv_mem[wr_addr[AW-1:0]] <= wr_kv_data;
    if (rd_en) begin
      rd_meta <= meta_mem[rd_addr[AW-1:0]];
      rd_kv   <= kv_mem[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        key_r <= in_key;
        val_r <= in_value;
        h_r   <= PW'(in_home);
        freeb <= PW'(in_home);
        i_r   <= IW'(N - 1);
      end
      OP_CAP_HOME: begin
        hop_r <= rd_hop;
        li    <= '0;
      end
      OP_LK_NEXT:   li <= li + LW'(1);
      OP_FREE_NEXT: freeb <= freeb + PW'(1);
      OP_I_DEC:     i_r <= i_r - IW'(1);
      OP_CAP_CAND: begin
        cand_r     <= cand_pos;
        cand_occ_r <= rd_meta[N];
        newbits_r  <= (rd_hop & ~(N'(1) << j)) | (N'(1) << i_r);
        from_r     <= cand_pos + PW'(j);
      end
      OP_CAP_FROM: begin
        from_occ_r <= rd_meta[N];
        from_hop_r <= rd_hop;
        from_kv_r  <= rd_kv;
      end
      OP_W_CAND: begin
        freeb <= from_r;
        i_r   <= IW'(N - 1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (op == OP_CLEAR) clr <= clr + AW'(1);
      if (op == OP_EMIT_HIT || op == OP_EMIT_PLACED ||
          op == OP_EMIT_MISS || op == OP_EMIT_FULL) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_EMIT_HIT: begin
        out_code  <= CODE_DONE;
        out_value <= rd_kv[VAL_W-1:0];
        out_slot  <= lk_pos[HOME_W-1:0];
      end
      OP_EMIT_PLACED: begin
        out_code  <= CODE_DONE;
        out_value <= '0;
        out_slot  <= freeb[HOME_W-1:0];
      end
      OP_EMIT_MISS: begin
        out_code  <= CODE_MISS;
        out_value <= '0;
        out_slot  <= '0;
      end
      OP_EMIT_FULL: begin
        out_code  <= CODE_FULL;
        out_value <= '0;
        out_slot  <= '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    st.clr_last = (clr == AW'(TABLE_DEPTH - 1));
    st.home_ok  = (h_r < size_eff);
    st.lk_end   = (li == LW'(N));
    st.lk_cand  = hop_r[li[IW-1:0]] && (lk_pos < PW'(TABLE_DEPTH));
    st.lk_hit   = rd_meta[N] && (rd_kv[KW-1:VAL_W] == key_r);
    st.scan_ok  = (freeb < size_eff);
    st.free_occ = rd_meta[N];
    st.near     = (span < PW'(N));
    st.j_found  = j_found;
    st.i_last   = (i_r == IW'(1));
    st.out_free = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

### sv/hopscotch_hash_table.sv
`default_nettype none

// Hopscotch hash table, one item at a time, one result per item. Every step is one
// access to a single-read-port bucket memory, which sets the pace: a lookup reads the
// home bucket's hop bitmap, then reads and compares each bucket whose hop bit is set
// and misses when none holds the key (or when the home lies beyond the used size);
// an insert scans from the home up to a free slot, moves entries from candidate buckets
// toward it until it lies in the home's neighborhood, then places the key and raises the
// result. After reset a clearing pass over all TABLE_DEPTH buckets zeroes the occupied
// and hop bits before the first item is taken. A finished result sits in an output
// register, so the next item is taken while it waits.
module hopscotch_hash_table #(
  parameter int TABLE_DEPTH  = hht_pkg::DEPTH_DEF,
  parameter int NEIGHBORHOOD = hht_pkg::NBHD_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  hht_req_if.sink                            req,
  hht_rsp_if.source                          rsp,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [hht_pkg::APB_AW-1:0]    paddr,
  input  wire logic [hht_pkg::APB_DW-1:0]    pwdata,
  output logic [hht_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);
  import hht_pkg::*;

  `include "assert_macros.svh"

  logic [USED_W-1:0] used_size;
  hht_op_t           op;
  hht_st_t           st;
  logic              emitting;

  assign pready = 1'b1;
  assign prdata = APB_DW'(used_size);
  assign emitting = (op == OP_EMIT_HIT) || (op == OP_EMIT_PLACED) ||
                    (op == OP_EMIT_MISS) || (op == OP_EMIT_FULL);

  always_ff @(posedge clk) begin
    if (rst) begin
      used_size <= USED_SIZE_RST;
    end else if (psel && penable && pwrite && paddr[2] == REG_USED_SIZE) begin
      used_size <= pwdata[USED_W-1:0];
    end
  end

  hht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_insert (req.command),
    .st        (st),
    .op        (op),
    .in_ready  (req.ready)
  );

  hht_dp #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .NEIGHBORHOOD (NEIGHBORHOOD)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .st        (st),
    .in_key    (req.key),
    .in_value  (req.entry_value),
    .in_home   (req.home_bucket),
    .used_size (used_size),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_code  (rsp.result_code),
    .out_value (rsp.found_value),
    .out_slot  (rsp.slot)
  );

  `HHT_ASSERT_NEXT(a_one_item, req.valid && req.ready, !req.ready)
  `HHT_ASSERT_IMP(a_emit_room, emitting, st.out_free)
  `HHT_ASSERT_IMP(a_fail_zero, rsp.valid && rsp.result_code != CODE_DONE, rsp.found_value == 0 && rsp.slot == 0)

endmodule

`default_nettype wire
